// ===== rtl/core/a2i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared widths, codes and types of the ASCII number to integer converter.
// ----------------------------------------------------------------------------
package a2i_pkg;

    // Widest value the converter can hold.
    localparam int MAX_BITS = 80;

    // Field widths of the requests on both channels.
    localparam int CH_W     = 8;
    localparam int LOW_W    = 64;
    localparam int HIGH_W   = 16;
    localparam int OUT_W    = LOW_W + HIGH_W;
    localparam int STATUS_W = 2;

    // Configuration register.
    localparam int              CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd80;

    // Width of the clamped bit limit.
    localparam int LIM_W = $clog2(MAX_BITS + 1);

    // Accumulator, and the product plus digit before the overflow check.
    localparam int ACC_W  = MAX_BITS;
    localparam int NEXT_W = MAX_BITS + 5;
    localparam int DIG_W  = 4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DEC  = 2'd3;

    // Character codes.
    localparam logic [CH_W-1:0] CH_0  = 8'h30;
    localparam logic [CH_W-1:0] CH_9  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA = 8'h41;
    localparam logic [CH_W-1:0] CH_UF = 8'h46;
    localparam logic [CH_W-1:0] CH_LA = 8'h61;
    localparam logic [CH_W-1:0] CH_LF = 8'h66;
    localparam logic [CH_W-1:0] CH_X  = 8'h78;

    // Parse mode of the string under way.
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_ZERO  = 2'd1,
        MODE_DEC   = 2'd2,
        MODE_HEX   = 2'd3
    } t_mode;

endpackage

// ===== rtl/core/a2i_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_char_if
// Character channel: one string character per request, with framing marks.
// ----------------------------------------------------------------------------
interface a2i_char_if;
    logic                      valid;
    logic                      ready;
    logic [a2i_pkg::CH_W-1:0]  ch;
    logic                      first;
    logic                      last;
    logic                      empty_req;

    modport source (output valid, output ch, output first, output last,
                    output empty_req, input ready);
    modport sink   (input valid, input ch, input first, input last,
                    input empty_req, output ready);
endinterface

// ===== rtl/core/a2i_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2i_result_if
// Result channel: converted value split into two words, plus a status code.
// ----------------------------------------------------------------------------
interface a2i_result_if;
    logic                          valid;
    logic                          ready;
    logic [a2i_pkg::LOW_W-1:0]     value_low;
    logic [a2i_pkg::HIGH_W-1:0]    value_high;
    logic [a2i_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output value_low, output value_high,
                    output status, input ready);
    modport sink   (input valid, input value_low, input value_high,
                    input status, output ready);
endinterface

// ===== rtl/core/ascii_number_to_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_number_to_integer
// Converts a stream of ASCII characters, one number string at a time, into
// an integer of up to 80 bits with a status code.
// ----------------------------------------------------------------------------
// The block takes one character request per clock and returns one result
// request for each request that carries the last mark; the last character
// is held in the input register and its result then in the output register, and a
// new character can be accepted every cycle as long as the result side keeps
// taking results. A string that begins with "0x" is read as hexadecimal
// (digits 0-9, A-F, a-f), any other string as decimal. Each digit does
// value = value * base + digit combinationally with a shift-and-add, and
// that 85-bit add plus the overflow check is the path that sets the clock.
// The status reports ok, overflow past the configured bit limit, a bad hex
// character or a bad decimal character; only the first error of a string is
// kept, and the value reads 0 whenever the status is not ok. An empty_req
// request carries no character, so an empty string (first, last and
// empty_req together) gives 0 with status ok. The bit limit may only be
// written while no string is in progress; a limit above 80 acts as 80 and a
// limit of 0 allows only the value 0.
// ----------------------------------------------------------------------------
module ascii_number_to_integer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [a2i_pkg::CFG_W-1:0]      i_cfg_wdata,
    a2i_char_if.sink                       i_char,
    a2i_result_if.source                   o_result
);

    // Configuration register.
    logic [a2i_pkg::CFG_W-1:0]     r_bit_limit;

    // Input register holding the character under work.
    logic                          r_in_valid;
    logic [a2i_pkg::CH_W-1:0]      r_ch;
    logic                          r_first;
    logic                          r_last;
    logic                          r_empty;

    // String state.
    logic [a2i_pkg::ACC_W-1:0]     r_acc;
    a2i_pkg::t_mode                r_mode;
    logic [a2i_pkg::STATUS_W-1:0]  r_err;

    // Result register.
    logic                          r_out_valid;
    logic [a2i_pkg::LOW_W-1:0]     r_value_low;
    logic [a2i_pkg::HIGH_W-1:0]    r_value_high;
    logic [a2i_pkg::STATUS_W-1:0]  r_status;

    // Next values.
    logic [a2i_pkg::ACC_W-1:0]     n_acc;
    a2i_pkg::t_mode                n_mode;
    logic [a2i_pkg::STATUS_W-1:0]  n_err;

    // Working signals.
    logic [a2i_pkg::ACC_W-1:0]     w_acc_base;
    a2i_pkg::t_mode                w_mode_base;
    logic [a2i_pkg::STATUS_W-1:0]  w_err_base;
    a2i_pkg::t_mode                w_mode_char;
    logic                          w_take;
    logic                          w_hex;
    logic                          w_is_dec;
    logic                          w_is_uhex;
    logic                          w_is_lhex;
    logic                          w_digit_ok;
    logic [a2i_pkg::DIG_W-1:0]     w_digit;
    logic [a2i_pkg::NEXT_W-1:0]    w_acc_wide;
    logic [a2i_pkg::NEXT_W-1:0]    w_next;
    logic [a2i_pkg::LIM_W-1:0]     w_lim;
    logic                          w_over;
    logic [a2i_pkg::ACC_W-1:0]     w_acc_char;
    logic [a2i_pkg::STATUS_W-1:0]  w_err_char;
    logic [a2i_pkg::OUT_W-1:0]     w_value;
    logic                          w_out_free;
    logic                          w_advance;

    // The stage advances when it holds a character and, if that character
    // ends a string, the result register can take the result.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_advance  = r_in_valid && (!r_last || w_out_free);
    assign i_char.ready = !r_in_valid || w_advance;

    // A first mark drops whatever string was under way.
    assign w_acc_base  = r_first ? '0 : r_acc;
    assign w_mode_base = r_first ? a2i_pkg::MODE_START : r_mode;
    assign w_err_base  = r_first ? a2i_pkg::ST_OK : r_err;

    // A character is looked at only when present and no error has been seen.
    assign w_take = !r_empty && (w_err_base == a2i_pkg::ST_OK);

    // Character classes.
    assign w_is_dec  = (r_ch >= a2i_pkg::CH_0)  && (r_ch <= a2i_pkg::CH_9);
    assign w_is_uhex = (r_ch >= a2i_pkg::CH_UA) && (r_ch <= a2i_pkg::CH_UF);
    assign w_is_lhex = (r_ch >= a2i_pkg::CH_LA) && (r_ch <= a2i_pkg::CH_LF);

    // Parse mode after this character.
    always_comb begin
        case (w_mode_base)
            a2i_pkg::MODE_START: begin
                w_mode_char = (r_ch == a2i_pkg::CH_0) ? a2i_pkg::MODE_ZERO
                                                      : a2i_pkg::MODE_DEC;
            end
            a2i_pkg::MODE_ZERO: begin
                w_mode_char = (r_ch == a2i_pkg::CH_X) ? a2i_pkg::MODE_HEX
                                                      : a2i_pkg::MODE_DEC;
            end
            a2i_pkg::MODE_DEC: begin
                w_mode_char = a2i_pkg::MODE_DEC;
            end
            a2i_pkg::MODE_HEX: begin
                w_mode_char = a2i_pkg::MODE_HEX;
            end
            default: begin
                w_mode_char = a2i_pkg::MODE_START;
            end
        endcase
    end

    // Next parse mode: a string that ends returns to its start.
    always_comb begin
        n_mode = w_mode_base;
        if (w_take) begin
            n_mode = w_mode_char;
        end
        if (r_last) begin
            n_mode = a2i_pkg::MODE_START;
        end
    end

    // Clamp the limit to the width of the accumulator.
    always_comb begin
        if (int'(r_bit_limit) > a2i_pkg::MAX_BITS) begin
            w_lim = a2i_pkg::LIM_W'(a2i_pkg::MAX_BITS);
        end else begin
            w_lim = a2i_pkg::LIM_W'(r_bit_limit);
        end
    end

    // Digit decode and accumulate. The "x" of a "0x" prefix is the one
    // character that is neither a digit nor an error.
    always_comb begin
        w_hex      = (w_mode_base == a2i_pkg::MODE_HEX);
        w_digit_ok = w_is_dec || (w_hex && (w_is_uhex || w_is_lhex));
        if (w_is_dec) begin
            w_digit = a2i_pkg::DIG_W'(r_ch - a2i_pkg::CH_0);
        end else if (w_is_uhex) begin
            w_digit = a2i_pkg::DIG_W'(r_ch - a2i_pkg::CH_UA + 8'd10);
        end else begin
            w_digit = a2i_pkg::DIG_W'(r_ch - a2i_pkg::CH_LA + 8'd10);
        end

        w_acc_wide = a2i_pkg::NEXT_W'(w_acc_base);
        if (w_hex) begin
            w_next = (w_acc_wide << 4) + a2i_pkg::NEXT_W'(w_digit);
        end else begin
            w_next = (w_acc_wide << 3) + (w_acc_wide << 1)
                   + a2i_pkg::NEXT_W'(w_digit);
        end

        // Any set bit at or above the limit is an overflow.
        w_over = 1'b0;
        for (int i = 0; i < a2i_pkg::NEXT_W; i++) begin
            if (w_next[i] && (i >= int'(w_lim))) begin
                w_over = 1'b1;
            end
        end

        w_acc_char = w_acc_base;
        w_err_char = w_err_base;
        if ((w_mode_base == a2i_pkg::MODE_ZERO) && (r_ch == a2i_pkg::CH_X)) begin
            w_err_char = w_err_base;
        end else if (!w_digit_ok) begin
            w_err_char = w_hex ? a2i_pkg::ST_BAD_HEX : a2i_pkg::ST_BAD_DEC;
        end else if (w_over) begin
            w_err_char = a2i_pkg::ST_OVERFLOW;
        end else begin
            w_acc_char = w_next[a2i_pkg::ACC_W-1:0];
        end

        if (w_take) begin
            n_acc = w_acc_char;
            n_err = w_err_char;
        end else begin
            n_acc = w_acc_base;
            n_err = w_err_base;
        end

        // An errored string reports a zero value.
        w_value = (n_err == a2i_pkg::ST_OK) ? a2i_pkg::OUT_W'(n_acc) : '0;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_limit <= a2i_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_bit_limit <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_ch    <= i_char.ch;
            r_first <= i_char.first;
            r_last  <= i_char.last;
            r_empty <= i_char.empty_req;
        end
    end

    // String state; a finished string is cleared for the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_mode <= a2i_pkg::MODE_START;
            r_err  <= a2i_pkg::ST_OK;
        end else if (w_advance) begin
            r_acc  <= r_last ? '0 : n_acc;
            r_mode <= n_mode;
            r_err  <= r_last ? a2i_pkg::ST_OK : n_err;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_last) begin
            r_value_low  <= w_value[a2i_pkg::LOW_W-1:0];
            r_value_high <= w_value[a2i_pkg::OUT_W-1:a2i_pkg::LOW_W];
            r_status     <= n_err;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.value_low  = r_value_low;
    assign o_result.value_high = r_value_high;
    assign o_result.status     = r_status;

endmodule
